@@ src/fpe_pkg.sv @@
`default_nettype none

package fpe_pkg;

   // Argument width taken into a conversion; the datapath is 32 bits wide.
   localparam int VALUE_BITS = 32;
   localparam int CONV_BITS  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam logic [31:0] ARG_MASK = 32'((64'd1 << CONV_BITS) - 64'd1);

   // Digit store geometry
   localparam int DIGIT_DEPTH = 32;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
   localparam int DIGIT_CNT_W = DIGIT_IDX_W + 1;

   // Reciprocal of ten, exact for every 32-bit dividend with a shift of 35
   localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] mode_type;
   typedef logic [1:0] base_type;

   // Terminal commands
   localparam cmd_type CMD_PUT     = 2'd0;
   localparam cmd_type CMD_NEWLINE = 2'd1;
   localparam cmd_type CMD_DELETE  = 2'd2;

   // Parser modes
   localparam mode_type MODE_NORMAL  = 2'd0;
   localparam mode_type MODE_ESCAPE  = 2'd1;
   localparam mode_type MODE_CONVERT = 2'd2;

   // Conversion radix codes
   localparam base_type BASE_DEC = 2'd0;
   localparam base_type BASE_BIN = 2'd1;
   localparam base_type BASE_HEX = 2'd2;
   localparam base_type BASE_OCT = 2'd3;

   // Characters the parser reacts to
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LINEFEED  = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_C     = 8'h63;
   localparam logic [7:0] CH_LOW_D     = 8'h64;
   localparam logic [7:0] CH_LOW_H     = 8'h68;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_O     = 8'h6F;
   localparam logic [7:0] CH_LOW_T     = 8'h74;

   // Digit value to uppercase ASCII
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'd0, d};
      end else begin
         c = CH_UPPER_A + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/format_print_engine_unit.sv @@
`default_nettype none

// Format print engine.
// Input channel (req_*): one format character per beat with a 32-bit
// argument and a last-character flag. Output channel (rsp_*): terminal
// commands (put character, newline, delete), run_last set on the final
// beat caused by an input. Both channels use valid/stall handshakes.
// One input is handled at a time: req_stall is high from the beat that
// starts work until the last result of that input sits in the output
// register. Characters that yield nothing (escape or percent lead-in,
// unknown codes) leave the sequencer idle, so req_stall stays low.
// Plain characters and escapes pass through ST_PUT to the output
// register; a tab gives three beats, one per cycle unless stalled.
// Conversions run a shared radix unit, one digit per iteration, into a
// 32-entry digit store, then read the digits back most significant first,
// one beat per cycle unless stalled. %h/%o/%b take a digit off by shift
// and mask in ST_DIV; %d passes ST_MUL (reciprocal multiply), then ST_DIV
// (remainder) per digit, so a 32-bit %d has up to 10 digits and %b 32.
// An output stall holds the current beat; only ST_PUT/ST_EMIT wait.
// Reset (synchronous) returns to normal text mode, idle, no output valid.

module format_print_engine_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [7:0]          req_format_char,
   input  wire  [31:0]         req_arg_value,
   input  wire                 req_format_last,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output fpe_pkg::cmd_type    rsp_command,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_run_last
);
   import fpe_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PUT  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]             state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [1:0]             rep_ff, rep_in;
   cmd_type                put_cmd_ff, put_cmd_in;
   logic [7:0]             put_chr_ff, put_chr_in;
   base_type               base_ff, base_in;
   logic [31:0]            work_ff, work_in;
   logic [63:0]            prod_ff, prod_in;
   logic [DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   cmd_type                out_cmd_ff, out_cmd_in;
   logic [7:0]             out_chr_ff, out_chr_in;
   logic                   out_last_ff, out_last_in;

   logic [3:0]             digit_store [DIGIT_DEPTH];

   logic                   accept;
   logic                   slot_free;
   logic                   emit_load;

   // Decoder outputs
   logic                   dec_put;
   logic [1:0]             dec_rep;
   cmd_type                dec_cmd;
   logic [7:0]             dec_chr;
   logic                   dec_conv;
   base_type               dec_base;
   mode_type               dec_mode;

   // Radix unit
   logic [28:0]            quot_ten;
   logic [31:0]            quot_ten_x10;
   logic [31:0]            ru_next;
   logic [3:0]             ru_digit;
   logic                   digit_wr;
   logic [DIGIT_IDX_W-1:0] rd_idx;
   logic [DIGIT_CNT_W-1:0] cnt_dec;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign emit_load = (state_ff == ST_EMIT) && slot_free;

   // Character decode
   always_comb begin
      dec_put  = 1'b0;
      dec_rep  = 2'd0;
      dec_cmd  = CMD_PUT;
      dec_chr  = CH_NUL;
      dec_conv = 1'b0;
      dec_base = BASE_DEC;
      dec_mode = MODE_NORMAL;
      case (mode_ff)
         MODE_ESCAPE: begin
            case (req_format_char)
               CH_LOW_N: begin
                  dec_put = 1'b1;
                  dec_cmd = CMD_NEWLINE;
               end
               CH_LOW_B: begin
                  dec_put = 1'b1;
                  dec_cmd = CMD_DELETE;
               end
               CH_LOW_T: begin
                  dec_put = 1'b1;
                  dec_rep = 2'd2;
                  dec_chr = CH_SPACE;
               end
               CH_BACKSLASH, CH_PERCENT: begin
                  dec_put = 1'b1;
                  dec_chr = req_format_char;
               end
               default: begin
               end
            endcase
         end
         MODE_CONVERT: begin
            case (req_format_char)
               CH_LOW_C: begin
                  dec_put = 1'b1;
                  dec_chr = req_arg_value[7:0];
               end
               CH_LOW_D: begin
                  dec_conv = 1'b1;
                  dec_base = BASE_DEC;
               end
               CH_LOW_B: begin
                  dec_conv = 1'b1;
                  dec_base = BASE_BIN;
               end
               CH_LOW_H: begin
                  dec_conv = 1'b1;
                  dec_base = BASE_HEX;
               end
               CH_LOW_O: begin
                  dec_conv = 1'b1;
                  dec_base = BASE_OCT;
               end
               default: begin
               end
            endcase
         end
         default: begin
            case (req_format_char)
               CH_LINEFEED: begin
                  dec_put = 1'b1;
                  dec_cmd = CMD_NEWLINE;
               end
               CH_BACKSPACE: begin
                  dec_put = 1'b1;
                  dec_cmd = CMD_DELETE;
               end
               CH_TAB: begin
                  dec_put = 1'b1;
                  dec_rep = 2'd2;
                  dec_chr = CH_SPACE;
               end
               CH_BACKSLASH: dec_mode = MODE_ESCAPE;
               CH_PERCENT:   dec_mode = MODE_CONVERT;
               default: begin
                  dec_put = 1'b1;
                  dec_chr = req_format_char;
               end
            endcase
         end
      endcase
      if (req_format_last) begin
         dec_mode = MODE_NORMAL;
      end
   end

   // Shared radix unit: one digit off the working value per iteration
   assign quot_ten     = prod_ff[63:RECIP_SHIFT];
   // quotient times ten as 8q + 2q
   assign quot_ten_x10 = {quot_ten, 3'b000} + {2'b00, quot_ten, 1'b0};
   always_comb begin
      ru_next  = work_ff;
      ru_digit = 4'd0;
      case (base_ff)
         BASE_BIN: begin
            ru_next  = {1'b0, work_ff[31:1]};
            ru_digit = {3'd0, work_ff[0]};
         end
         BASE_HEX: begin
            ru_next  = {4'd0, work_ff[31:4]};
            ru_digit = work_ff[3:0];
         end
         BASE_OCT: begin
            ru_next  = {3'd0, work_ff[31:3]};
            ru_digit = {1'b0, work_ff[2:0]};
         end
         default: begin
            ru_next  = {3'd0, quot_ten};
            ru_digit = 4'(work_ff - quot_ten_x10);
         end
      endcase
   end

   assign cnt_dec  = cnt_ff - DIGIT_CNT_W'(1);
   assign rd_idx   = cnt_dec[DIGIT_IDX_W-1:0];
   assign digit_wr = (state_ff == ST_DIV);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rep_in       = rep_ff;
      put_cmd_in   = put_cmd_ff;
      put_chr_in   = put_chr_ff;
      base_in      = base_ff;
      work_in      = work_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_cmd_in   = out_cmd_ff;
      out_chr_in   = out_chr_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in    = dec_mode;
               rep_in     = dec_rep;
               put_cmd_in = dec_cmd;
               put_chr_in = dec_chr;
               base_in    = dec_base;
               work_in    = req_arg_value & ARG_MASK;
               cnt_in     = '0;
               if (dec_put) begin
                  state_in = ST_PUT;
               end else if (dec_conv) begin
                  state_in = (dec_base == BASE_DEC) ? ST_MUL : ST_DIV;
               end
            end
         end
         ST_PUT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_cmd_in   = put_cmd_ff;
               out_chr_in   = put_chr_ff;
               out_last_in  = (rep_ff == 2'd0);
               rep_in       = rep_ff - 2'd1;
               if (rep_ff == 2'd0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL: begin
            prod_in  = {32'd0, work_ff} * {32'd0, RECIP_TEN};
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // do-while: a zero value still leaves one '0' digit
            work_in = ru_next;
            cnt_in  = cnt_ff + DIGIT_CNT_W'(1);
            if (ru_next == 32'd0) begin
               state_in = ST_EMIT;
            end else if (base_ff == BASE_DEC) begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            // digit character is loaded by the clocked store read
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_cmd_in   = CMD_PUT;
               out_last_in  = (cnt_ff == DIGIT_CNT_W'(1));
               cnt_in       = cnt_dec;
               if (cnt_ff == DIGIT_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_NORMAL;
         work_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         work_ff      <= work_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_ff     <= rep_in;
      put_cmd_ff <= put_cmd_in;
      put_chr_ff <= put_chr_in;
      base_ff    <= base_in;
      prod_ff    <= prod_in;
      out_cmd_ff <= out_cmd_in;
      out_last_ff <= out_last_in;
      // registered digit read straight into the output character
      if (emit_load) begin
         out_chr_ff <= digit_char(digit_store[rd_idx]);
      end else begin
         out_chr_ff <= out_chr_in;
      end
   end

   // Digit store
   always_ff @(posedge clock) begin
      if (digit_wr) begin
         digit_store[cnt_ff[DIGIT_IDX_W-1:0]] <= ru_digit;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_command  = out_cmd_ff;
   assign rsp_out_char = out_chr_ff;
   assign rsp_run_last = out_last_ff;

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DIGIT_CNT_W'(DIGIT_DEPTH))
      else $error("digit count beyond store depth");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff != '0))
      else $error("emitting with no stored digits");

   a_dec_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && base_ff == BASE_DEC) |-> (ru_digit < 4'd10))
      else $error("decimal remainder out of range");

   a_div_store_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < DIGIT_CNT_W'(DIGIT_DEPTH)))
      else $error("digit write past store end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_command)
         && $stable(rsp_out_char) && $stable(rsp_run_last)))
      else $error("stalled result beat changed");

endmodule

`default_nettype wire

@@ tb/tb_format_print_engine_unit.sv @@
`timescale 1ns / 100ps

module tb_format_print_engine_unit;
   import fpe_pkg::*;

   localparam logic [7:0] CH_LOW_Q = 8'h71;
   localparam logic [7:0] CH_LOW_S = 8'h73;
   localparam int NUM_RANDOM_ITEMS = 190;

   // One terminal beat as seen on the result channel
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] ch;
      logic       last;
   } term_beat_type;

   // Tracks the parser mode and holds the terminal beats still owed by the block
   class print_scoreboard;
      mode_type      parse_state;
      term_beat_type owed_beats[$];
      int            mismatches;
      int            beats_checked;
      int            chars_taken;
      int            conversions;

      function new();
         parse_state   = MODE_NORMAL;
         mismatches    = 0;
         beats_checked = 0;
         chars_taken   = 0;
         conversions   = 0;
      endfunction

      task report(input string msg);
         mismatches++;
         if (mismatches <= 40) begin
            $display("ERROR @%0t: %s", $time, msg);
         end
      endtask

      // Expected digits of an unsigned number, most significant first
      function void add_number(ref term_beat_type run[$], input logic [31:0] arg,
                               input int radix);
         logic [31:0] rest;
         int          digit;
         logic [7:0]  digit_chars[$];
         rest = arg & ARG_MASK;
         conversions++;
         if (rest == 32'd0) begin
            digit_chars.push_front(CH_ZERO);
         end
         while (rest != 32'd0) begin
            digit = int'(rest % radix);
            if (digit < 10) begin
               digit_chars.push_front(CH_ZERO + 8'(digit));
            end else begin
               digit_chars.push_front(CH_UPPER_A + 8'(digit - 10));
            end
            rest = rest / radix;
         end
         foreach (digit_chars[k]) begin
            run.push_back('{CMD_PUT, digit_chars[k], 1'b0});
         end
      endfunction

      function void add_spaces(ref term_beat_type run[$]);
         repeat (3) run.push_back('{CMD_PUT, CH_SPACE, 1'b0});
      endfunction

      // Predict the beats caused by one accepted format character
      function void note_input(input logic [7:0] ch, input logic [31:0] arg,
                               input logic last);
         term_beat_type run[$];
         chars_taken++;
         case (parse_state)
            MODE_ESCAPE: begin
               parse_state = MODE_NORMAL;
               case (ch)
                  CH_LOW_N:     run.push_back('{CMD_NEWLINE, 8'h00, 1'b0});
                  CH_LOW_B:     run.push_back('{CMD_DELETE, 8'h00, 1'b0});
                  CH_LOW_T:     add_spaces(run);
                  CH_BACKSLASH: run.push_back('{CMD_PUT, CH_BACKSLASH, 1'b0});
                  CH_PERCENT:   run.push_back('{CMD_PUT, CH_PERCENT, 1'b0});
                  default: ;   // unknown escape prints nothing
               endcase
            end
            MODE_CONVERT: begin
               parse_state = MODE_NORMAL;
               case (ch)
                  CH_LOW_C: run.push_back('{CMD_PUT, arg[7:0], 1'b0});
                  CH_LOW_D: add_number(run, arg, 10);
                  CH_LOW_B: add_number(run, arg, 2);
                  CH_LOW_H: add_number(run, arg, 16);
                  CH_LOW_O: add_number(run, arg, 8);
                  default: ;   // unknown conversion prints nothing
               endcase
            end
            default: begin
               parse_state = MODE_NORMAL;
               case (ch)
                  CH_LINEFEED:  run.push_back('{CMD_NEWLINE, 8'h00, 1'b0});
                  CH_BACKSPACE: run.push_back('{CMD_DELETE, 8'h00, 1'b0});
                  CH_TAB:       add_spaces(run);
                  CH_BACKSLASH: parse_state = MODE_ESCAPE;
                  CH_PERCENT:   parse_state = MODE_CONVERT;
                  default:      run.push_back('{CMD_PUT, ch, 1'b0});
               endcase
            end
         endcase
         // a final character drops any pending lead-in
         if (last) begin
            parse_state = MODE_NORMAL;
         end
         if (run.size() > 0) begin
            run[run.size() - 1].last = 1'b1;
         end
         foreach (run[k]) begin
            owed_beats.push_back(run[k]);
         end
      endfunction

      // Compare one accepted result beat with the oldest owed beat
      task check_result(input cmd_type cmd, input logic [7:0] ch, input logic last);
         term_beat_type want;
         beats_checked++;
         if (owed_beats.size() == 0) begin
            report($sformatf("unexpected beat cmd=%0d char=%02h last=%0b",
                             cmd, ch, last));
         end else begin
            want = owed_beats.pop_front();
            if (cmd !== want.cmd) begin
               report($sformatf("command %0d, wanted %0d", cmd, want.cmd));
            end
            if (ch !== want.ch) begin
               report($sformatf("out_char %02h, wanted %02h", ch, want.ch));
            end
            if (last !== want.last) begin
               report($sformatf("run_last %0b, wanted %0b", last, want.last));
            end
         end
      endtask
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_format_char = 8'h00;
   logic [31:0] req_arg_value = 32'h0;
   logic       req_format_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   cmd_type    rsp_command;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;

   print_scoreboard sb = new();
   int burst_left = 0;

   format_print_engine_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_format_char (req_format_char),
      .req_arg_value   (req_arg_value),
      .req_format_last (req_format_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Present one character and hold it until the block takes the beat;
   // between bursts the sender may go quiet for a random gap
   task automatic send_char(input logic [7:0] ch, input logic [31:0] arg,
                            input logic last);
      int gap;
      req_valid       <= 1'b1;
      req_format_char <= ch;
      req_arg_value   <= arg;
      req_format_last <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_input(ch, arg, last);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [31:0] pick_arg();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'($urandom_range(0, 20));
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [7:0] pick_conversion();
      case ($urandom_range(0, 10))
         0, 1:    return CH_LOW_C;
         2, 3:    return CH_LOW_D;
         4, 5:    return CH_LOW_B;
         6, 7:    return CH_LOW_H;
         8, 9:    return CH_LOW_O;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_escape();
      case ($urandom_range(0, 6))
         0:       return CH_LOW_N;
         1:       return CH_LOW_B;
         2:       return CH_LOW_T;
         3:       return CH_BACKSLASH;
         4:       return CH_PERCENT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Receiver stall: switches at random between several patterns
   int stall_style = 0;
   int style_left  = 0;
   int stall_run   = 0;
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 3);
         style_left  = $urandom_range(50, 300);
      end else begin
         style_left--;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= (cycle_count % 3 == 0);
         default: begin
            if (stall_run == 0) begin
               stall_run = $urandom_range(1, 10);
            end else begin
               stall_run--;
            end
            rsp_stall <= (stall_run > 2);
         end
      endcase
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_result(rsp_command, rsp_out_char, rsp_run_last);
      end
   end

   // Stimulus
   initial begin
      logic [7:0] esc_codes[6];
      logic [7:0] conv_codes[6];
      logic [31:0] conv_args[6];
      logic [7:0] ch;
      int kind;
      int sent;
      esc_codes  = '{CH_LOW_N, CH_LOW_B, CH_LOW_T, CH_BACKSLASH, CH_PERCENT, CH_LOW_Q};
      conv_codes = '{CH_LOW_C, CH_LOW_D, CH_LOW_B, CH_LOW_H, CH_LOW_O, CH_LOW_S};
      conv_args  = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
                     32'hFFFF_FFFF, 32'h1234};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: control characters, NUL, every escape and conversion
      send_char(CH_NUL, 32'h0, 1'b0);
      send_char(CH_LINEFEED, 32'h0, 1'b0);
      send_char(CH_BACKSPACE, 32'h0, 1'b0);
      send_char(CH_TAB, 32'h0, 1'b0);
      foreach (esc_codes[k]) begin
         send_char(CH_BACKSLASH, 32'h0, 1'b0);
         send_char(esc_codes[k], 32'hFFFF_FFFF, 1'b0);
      end
      foreach (conv_codes[k]) begin
         send_char(CH_PERCENT, 32'h0, 1'b0);
         send_char(conv_codes[k], conv_args[k], k == 5);
      end
      // percent on the final character is dropped; 'd' then prints plainly
      send_char(CH_PERCENT, 32'h5, 1'b1);
      send_char(CH_LOW_D, 32'h5, 1'b1);

      // Random: mostly well-formed escapes and conversions, some noise
      sent = 0;
      while (sent < NUM_RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            send_char(CH_PERCENT, pick_arg(), 1'b0);
            send_char(pick_conversion(), pick_arg(), $urandom_range(0, 5) == 0);
            sent += 2;
         end else if (kind < 52) begin
            send_char(CH_BACKSLASH, pick_arg(), 1'b0);
            send_char(pick_escape(), pick_arg(), $urandom_range(0, 5) == 0);
            sent += 2;
         end else if (kind < 62) begin
            case ($urandom_range(0, 2))
               0:       ch = CH_LINEFEED;
               1:       ch = CH_BACKSPACE;
               default: ch = CH_TAB;
            endcase
            send_char(ch, pick_arg(), $urandom_range(0, 7) == 0);
            sent += 1;
         end else if (kind < 94) begin
            send_char(8'($urandom_range(0, 255)), pick_arg(), $urandom_range(0, 7) == 0);
            sent += 1;
         end else begin
            // lead-in cut off by the final flag, then any character
            send_char($urandom_range(0, 1) ? CH_PERCENT : CH_BACKSLASH, pick_arg(), 1'b1);
            send_char(8'($urandom_range(0, 255)), pick_arg(), 1'($urandom_range(0, 1)));
            sent += 2;
         end
      end
      req_valid <= 1'b0;

      // Drain, then watch for stray beats
      while (sb.owed_beats.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Took %0d format characters, checked %0d terminal beats.",
               sb.chars_taken, sb.beats_checked);
      $display("Number conversions predicted: %0d, mismatches: %0d.",
               sb.conversions, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb_format_print_engine_unit: PASS");
      end else begin
         $display("tb_format_print_engine_unit: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("Timed out with %0d beats still owed.", sb.owed_beats.size());
      $display("tb_format_print_engine_unit: FAIL");
      $finish;
   end

endmodule
